// ----- sv/integer_matrix_multiply_core_macros.svh -----
// assertion helpers used by the rtl controller
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define IMM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define IMM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/imm_pkg.sv -----
package imm_pkg;

    // default size of the square operand and result stores
    localparam int MAX_DIM_DEF = 16;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 4;
    localparam int DIM_W  = 5;

    // configuration port
    localparam int APB_W   = 32;
    localparam int PADDR_W = 4;
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;
    localparam logic [1:0] REG_A_ROWS     = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_B_COLS     = 2'd2;

    // operation carried with every input transaction
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_READ_C  = 2'd3
    } op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic a_we;
        logic b_we;
        logic issue;
        logic first;
        logic last;
        logic zero;
        logic clear_we;
        logic res_set;
        logic res_status;
        logic res_mem;
        logic out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/imm_ram.sv -----
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/imm_ctrl.sv -----
`include "integer_matrix_multiply_core_macros.svh"

module imm_ctrl #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    localparam int DW = $clog2(MAX_DIM + 1),
    localparam int IW = $clog2(MAX_DIM),
    localparam int CELLS = MAX_DIM * MAX_DIM,
    localparam int AW = $clog2(CELLS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid_i,
    output logic                          s_ready_o,
    input  imm_pkg::op_t                  op_i,
    input  logic [imm_pkg::IDX_W-1:0]     row_i,
    input  logic [imm_pkg::IDX_W-1:0]     col_i,
    input  logic [imm_pkg::DIM_W-1:0]     a_rows_i,
    input  logic [imm_pkg::DIM_W-1:0]     inner_size_i,
    input  logic [imm_pkg::DIM_W-1:0]     b_cols_i,
    output imm_pkg::cmd_t                 cmd_o,
    input  imm_pkg::stat_t                stat_i,
    output logic [IW-1:0]                 run_row_o,
    output logic [IW-1:0]                 run_inner_o,
    output logic [IW-1:0]                 run_col_o,
    output logic [AW-1:0]                 clr_addr_o
);

    localparam int CMPW = (DW > imm_pkg::DIM_W) ? DW : imm_pkg::DIM_W;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] row_cnt_reg, row_cnt_next;
    logic [IW-1:0] k_cnt_reg, k_cnt_next;
    logic [IW-1:0] col_cnt_reg, col_cnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [DW-1:0] rows, shared, cols, k_max;
    logic          a_ok, b_ok, c_ok;
    logic          k_last, col_last, row_last;

    // dimension clamped to the store size
    function automatic logic [DW-1:0] eff_dim(input logic [imm_pkg::DIM_W-1:0] v);
        logic [CMPW-1:0] vw;
        vw = CMPW'(v);
        if (vw > CMPW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return DW'(vw);
    endfunction

    assign rows   = eff_dim(a_rows_i);
    assign shared = eff_dim(inner_size_i);
    assign cols   = eff_dim(b_cols_i);

    // index range checks for element access
    assign a_ok = (CMPW'(row_i) < CMPW'(rows)) && (CMPW'(col_i) < CMPW'(shared));
    assign b_ok = (CMPW'(row_i) < CMPW'(shared)) && (CMPW'(col_i) < CMPW'(cols));
    assign c_ok = (CMPW'(row_i) < CMPW'(rows)) && (CMPW'(col_i) < CMPW'(cols));

    // loop bounds; an empty inner dimension runs one zero term per element
    assign k_max    = (shared == '0) ? '0 : shared - DW'(1);
    assign k_last   = (DW'(k_cnt_reg) == k_max);
    assign col_last = (DW'(col_cnt_reg) == cols - DW'(1));
    assign row_last = (DW'(row_cnt_reg) == rows - DW'(1));

    // sequencing of the operations
    always_comb begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        k_cnt_next    = k_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        clr_addr_next = clr_addr_reg;
        cmd_o         = '0;
        s_ready_o     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd_o.clear_we = 1'b1;
                if (clr_addr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                s_ready_o = 1'b1;
                if (s_valid_i) begin
                    case (op_i)
                        imm_pkg::OP_WRITE_A: begin
                            cmd_o.a_we       = a_ok;
                            cmd_o.res_set    = 1'b1;
                            cmd_o.res_status = !a_ok;
                            state_next       = ST_RESP;
                        end
                        imm_pkg::OP_WRITE_B: begin
                            cmd_o.b_we       = b_ok;
                            cmd_o.res_set    = 1'b1;
                            cmd_o.res_status = !b_ok;
                            state_next       = ST_RESP;
                        end
                        imm_pkg::OP_COMPUTE: begin
                            cmd_o.res_set = 1'b1;
                            row_cnt_next  = '0;
                            k_cnt_next    = '0;
                            col_cnt_next  = '0;
                            if (rows != '0 && cols != '0) begin
                                state_next = ST_RUN;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        imm_pkg::OP_READ_C: begin
                            if (c_ok) begin
                                state_next = ST_READ;
                            end else begin
                                cmd_o.res_set    = 1'b1;
                                cmd_o.res_status = 1'b1;
                                state_next       = ST_RESP;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd_o.res_mem = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RUN: begin
                cmd_o.issue = 1'b1;
                cmd_o.first = (k_cnt_reg == '0);
                cmd_o.last  = k_last;
                cmd_o.zero  = (shared == '0);
                if (!k_last) begin
                    k_cnt_next = k_cnt_reg + IW'(1);
                end else begin
                    k_cnt_next = '0;
                    if (!col_last) begin
                        col_cnt_next = col_cnt_reg + IW'(1);
                    end else begin
                        col_cnt_next = '0;
                        if (!row_last) begin
                            row_cnt_next = row_cnt_reg + IW'(1);
                        end else begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!stat_i.pipe_busy) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (stat_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            row_cnt_reg  <= '0;
            k_cnt_reg    <= '0;
            col_cnt_reg  <= '0;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            k_cnt_reg    <= k_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign run_row_o   = row_cnt_reg;
    assign run_inner_o = k_cnt_reg;
    assign run_col_o   = col_cnt_reg;
    assign clr_addr_o  = clr_addr_reg;

    // checks on the sequencing
    `IMM_ASSERT_NEXT(a_compute_starts, aclk, aresetn,
        state_reg == ST_IDLE && s_valid_i && op_i == imm_pkg::OP_COMPUTE && rows != '0 && cols != '0,
        state_reg == ST_RUN, "compute transaction did not start the run")
    `IMM_ASSERT_SAME(a_out_free, aclk, aresetn, cmd_o.out_load, stat_i.out_free,
        "result loaded into a full output register")
    `IMM_ASSERT_SAME(a_resp_drained, aclk, aresetn, state_reg == ST_RESP, !stat_i.pipe_busy,
        "result issued while products are still in flight")
    `IMM_ASSERT_NEXT(a_clear_full, aclk, aresetn,
        state_reg == ST_CLEAR && clr_addr_reg != AW'(CELLS - 1), state_reg == ST_CLEAR,
        "clear pass left before the last entry")

endmodule

// ----- sv/imm_dpath.sv -----
module imm_dpath #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    localparam int IW = $clog2(MAX_DIM),
    localparam int CELLS = MAX_DIM * MAX_DIM,
    localparam int AW = $clog2(CELLS)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  imm_pkg::cmd_t                     cmd_i,
    output imm_pkg::stat_t                    stat_o,
    input  logic [IW-1:0]                     run_row_i,
    input  logic [IW-1:0]                     run_inner_i,
    input  logic [IW-1:0]                     run_col_i,
    input  logic [AW-1:0]                     clr_addr_i,
    input  logic [imm_pkg::IDX_W-1:0]         row_i,
    input  logic [imm_pkg::IDX_W-1:0]         col_i,
    input  logic signed [imm_pkg::DATA_W-1:0] element_value_i,
    input  logic                              m_ready_i,
    output logic                              m_valid_o,
    output logic signed [imm_pkg::DATA_W-1:0] read_value_o,
    output logic                              status_o
);

    localparam int DW = imm_pkg::DATA_W;

    logic [AW-1:0] io_addr, a_raddr, b_raddr, run_caddr;
    logic [DW-1:0] a_rdata, b_rdata, c_rdata;
    logic          c_we;
    logic [AW-1:0] c_waddr;
    logic [DW-1:0] c_wdata;

    logic          s1_valid_reg, s1_first_reg, s1_last_reg, s1_zero_reg;
    logic [AW-1:0] s1_caddr_reg;
    logic          s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [AW-1:0] s2_caddr_reg;
    logic [DW-1:0] prod_reg, prod_next;
    logic          s3_valid_reg, s3_last_reg;
    logic [AW-1:0] s3_caddr_reg;
    logic [DW-1:0] acc_reg, acc_next;

    logic [DW-1:0] res_value_reg;
    logic          res_status_reg;
    logic          out_valid_reg;
    logic [DW-1:0] out_value_reg;
    logic          out_status_reg;

    // row-major position in a square store
    function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
        return AW'(r * AW'(MAX_DIM) + c);
    endfunction

    assign io_addr   = cell_addr(AW'(row_i), AW'(col_i));
    assign a_raddr   = cell_addr(AW'(run_row_i), AW'(run_inner_i));
    assign b_raddr   = cell_addr(AW'(run_inner_i), AW'(run_col_i));
    assign run_caddr = cell_addr(AW'(run_row_i), AW'(run_col_i));

    // operand stores
    imm_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_a_ram (
        .clk   (aclk),
        .we    (cmd_i.a_we),
        .waddr (io_addr),
        .wdata (element_value_i),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_b_ram (
        .clk   (aclk),
        .we    (cmd_i.b_we),
        .waddr (io_addr),
        .wdata (element_value_i),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // product store, written by the clear pass or the accumulator
    assign c_we    = cmd_i.clear_we | (s3_valid_reg & s3_last_reg);
    assign c_waddr = cmd_i.clear_we ? clr_addr_i : s3_caddr_reg;
    assign c_wdata = cmd_i.clear_we ? '0 : acc_reg;

    imm_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_c_ram (
        .clk   (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (io_addr),
        .rdata (c_rdata)
    );

    // low word of the product; the upper half never reaches the sum
    assign prod_next = s1_zero_reg ? '0 : DW'(a_rdata * b_rdata);
    assign acc_next  = (s2_first_reg ? '0 : acc_reg) + prod_reg;

    // multiply-accumulate pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd_i.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // multiply-accumulate pipeline payload
    always_ff @(posedge aclk) begin
        s1_first_reg <= cmd_i.first;
        s1_last_reg  <= cmd_i.last;
        s1_zero_reg  <= cmd_i.zero;
        s1_caddr_reg <= run_caddr;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_caddr_reg <= s1_caddr_reg;
        prod_reg     <= prod_next;
        s3_last_reg  <= s2_last_reg;
        s3_caddr_reg <= s2_caddr_reg;
        if (s2_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    // pending result of the current transaction
    always_ff @(posedge aclk) begin
        if (cmd_i.res_set) begin
            res_value_reg  <= '0;
            res_status_reg <= cmd_i.res_status;
        end else if (cmd_i.res_mem) begin
            res_value_reg  <= c_rdata;
            res_status_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready_i) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat_o.pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign stat_o.out_free  = !out_valid_reg || m_ready_i;

    assign m_valid_o    = out_valid_reg;
    assign read_value_o = out_value_reg;
    assign status_o     = out_status_reg;

endmodule

// ----- sv/integer_matrix_multiply_core.sv -----
// Signed 32-bit matrix product C = A x B with on-chip stores for A, B and C.
// Input stream: s_tuser carries the operation (write A, write B, compute,
// read C), s_tdata the row and column index and the element to write.
// Every input transaction returns exactly one result transaction on the
// master side: the element of C for a read, zero otherwise, and an error
// flag in m_tuser when the index lies outside the configured dimensions.
// Dimensions are set through the APB port while the core is idle; the user
// must keep to this, the core itself does not enforce it.
// Compute runs on the single multiply-accumulate unit, fed from one read
// port on each operand store.
// After reset the product store is cleared while s_tready stays low;
// APB writes are taken during that pass.
// A result waiting on a stalled m_tready does not stop the next input
// transaction from being accepted; that transaction's result waits in
// turn until the output register frees.
module integer_matrix_multiply_core #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    localparam int IW = $clog2(MAX_DIM),
    localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // row_index, col_index, element_value
    input  logic [imm_pkg::OP_W-1:0]      s_tuser,  // op
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // read_value
    output logic                          m_tuser,  // status
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imm_pkg::PADDR_W-1:0]   paddr,
    input  logic [imm_pkg::APB_W-1:0]     pwdata,
    output logic [imm_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    localparam int PADW = imm_pkg::APB_W - imm_pkg::DIM_W;

    logic [imm_pkg::DIM_W-1:0] a_rows_reg, inner_size_reg, b_cols_reg;
    logic                      cfg_wr;
    logic [1:0]                reg_idx;

    imm_pkg::op_t                      op;
    logic [imm_pkg::IDX_W-1:0]         row_index, col_index;
    logic signed [imm_pkg::DATA_W-1:0] element_value;
    logic signed [imm_pkg::DATA_W-1:0] read_value;

    imm_pkg::cmd_t  cmd;
    imm_pkg::stat_t stat;
    logic [IW-1:0]  run_row, run_inner, run_col;
    logic [AW-1:0]  clr_addr;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg     <= imm_pkg::DIM_RESET;
            inner_size_reg <= imm_pkg::DIM_RESET;
            b_cols_reg     <= imm_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                imm_pkg::REG_A_ROWS:     a_rows_reg     <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_INNER_SIZE: inner_size_reg <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_B_COLS:     b_cols_reg     <= pwdata[imm_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            imm_pkg::REG_A_ROWS:     prdata = {{PADW{1'b0}}, a_rows_reg};
            imm_pkg::REG_INNER_SIZE: prdata = {{PADW{1'b0}}, inner_size_reg};
            imm_pkg::REG_B_COLS:     prdata = {{PADW{1'b0}}, b_cols_reg};
            default:                 prdata = '0;
        endcase
    end

    // input transaction fields
    assign op            = imm_pkg::op_t'(s_tuser);
    assign row_index     = s_tdata[3:0];
    assign col_index     = s_tdata[7:4];
    assign element_value = s_tdata[39:8];

    imm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid_i    (s_tvalid),
        .s_ready_o    (s_tready),
        .op_i         (op),
        .row_i        (row_index),
        .col_i        (col_index),
        .a_rows_i     (a_rows_reg),
        .inner_size_i (inner_size_reg),
        .b_cols_i     (b_cols_reg),
        .cmd_o        (cmd),
        .stat_i       (stat),
        .run_row_o    (run_row),
        .run_inner_o  (run_inner),
        .run_col_o    (run_col),
        .clr_addr_o   (clr_addr)
    );

    imm_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_i           (cmd),
        .stat_o          (stat),
        .run_row_i       (run_row),
        .run_inner_i     (run_inner),
        .run_col_i       (run_col),
        .clr_addr_i      (clr_addr),
        .row_i           (row_index),
        .col_i           (col_index),
        .element_value_i (element_value),
        .m_ready_i       (m_tready),
        .m_valid_o       (m_tvalid),
        .read_value_o    (read_value),
        .status_o        (m_tuser)
    );

    assign m_tdata = read_value;

endmodule

// ----- verif/integer_matrix_multiply_core_tb.sv -----
`timescale 1ns / 100ps

module integer_matrix_multiply_core_tb;

    localparam int DIM        = imm_pkg::MAX_DIM_DEF;
    localparam int CELLS      = DIM * DIM;
    localparam int ITEM_COUNT = 1500;
    localparam int STALL_LIMIT = 20000;

    // one result transaction: element of C and index error flag
    typedef struct packed {
        logic [31:0] read_value;
        logic        status;
    } mm_result_t;

    // one element access prepared by the stimulus
    typedef struct {
        imm_pkg::op_t op;
        logic [3:0]   row;
        logic [3:0]   col;
    } elem_ref_t;

    // mirror of the core: operand stores, product store, dimensions
    class product_scoreboard;
        logic [31:0] a_mem [0:CELLS-1];
        logic [31:0] b_mem [0:CELLS-1];
        logic [31:0] c_mem [0:CELLS-1];
        logic [4:0]  dim_reg [0:2];
        mm_result_t  expected_results [$];
        int          mismatches;

        function new();
            foreach (a_mem[i]) begin
                a_mem[i] = '0;
                b_mem[i] = '0;
                c_mem[i] = '0;
            end
            foreach (dim_reg[i]) dim_reg[i] = imm_pkg::DIM_RESET;
            mismatches = 0;
        endfunction

        // register value saturates at the store size
        function int unsigned eff_dim(int idx);
            return (dim_reg[idx] > DIM) ? DIM : dim_reg[idx];
        endfunction

        function void set_dim(logic [1:0] reg_idx, logic [4:0] value);
            dim_reg[reg_idx] = value;
        endfunction

        // rewrite the rows x cols region of C
        function void form_product();
            int unsigned rows, inner, cols;
            logic [31:0] acc;
            rows  = eff_dim(imm_pkg::REG_A_ROWS);
            inner = eff_dim(imm_pkg::REG_INNER_SIZE);
            cols  = eff_dim(imm_pkg::REG_B_COLS);
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    acc = '0;
                    for (int k = 0; k < inner; k++)
                        acc += a_mem[r*DIM+k] * b_mem[k*DIM+c];
                    c_mem[r*DIM+c] = acc;
                end
            end
        endfunction

        // apply one accepted input and queue the result it produces
        function void note_item(imm_pkg::op_t op, logic [3:0] row, logic [3:0] col,
                                logic [31:0] value);
            int unsigned rows, inner, cols;
            mm_result_t res;
            rows  = eff_dim(imm_pkg::REG_A_ROWS);
            inner = eff_dim(imm_pkg::REG_INNER_SIZE);
            cols  = eff_dim(imm_pkg::REG_B_COLS);
            res = '0;
            case (op)
                imm_pkg::OP_WRITE_A: begin
                    if (row < rows && col < inner) a_mem[row*DIM+col] = value;
                    else res.status = 1'b1;
                end
                imm_pkg::OP_WRITE_B: begin
                    if (row < inner && col < cols) b_mem[row*DIM+col] = value;
                    else res.status = 1'b1;
                end
                imm_pkg::OP_COMPUTE: form_product();
                default: begin
                    if (row < rows && col < cols) res.read_value = c_mem[row*DIM+col];
                    else res.status = 1'b1;
                end
            endcase
            expected_results.push_back(res);
        endfunction

        // compare one accepted result against the oldest expectation
        function void check_result(logic [31:0] read_value, logic status);
            mm_result_t exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, actual read_value %h status %b",
                         $time, read_value, status);
                mismatches++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (read_value !== exp_res.read_value) begin
                $display("%0t: read_value mismatch, expected %h, actual %h",
                         $time, exp_res.read_value, read_value);
                mismatches++;
            end
            if (status !== exp_res.status) begin
                $display("%0t: status mismatch, expected %b, actual %b",
                         $time, exp_res.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // row_index, col_index, element_value
    logic [imm_pkg::OP_W-1:0] s_tuser;  // op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_value
    logic        m_tuser;   // status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [imm_pkg::PADDR_W-1:0] paddr;
    logic [imm_pkg::APB_W-1:0]   pwdata;
    logic [imm_pkg::APB_W-1:0]   prdata;
    logic                        pready;

    product_scoreboard sb;

    // stimulus side view of the dimensions and of which operands hold data
    int unsigned gen_rows, gen_inner, gen_cols;
    bit          a_written [0:CELLS-1];
    bit          b_written [0:CELLS-1];
    bit          no_gaps;
    int          items_sent;
    int          idle_cycles;

    integer_matrix_multiply_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // input transaction monitor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(imm_pkg::op_t'(s_tuser), s_tdata[3:0], s_tdata[7:4],
                         s_tdata[39:8]);
    end

    // result transaction monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side backpressure: ready bursts, mostly short stalls, a few long
    initial begin
        int hold;
        int pick;
        m_tready = 1'b0;
        forever begin
            hold = $urandom_range(1, 30);
            repeat (hold) begin
                @(negedge aclk);
                m_tready = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) hold = 0;
            else if (pick < 90) hold = $urandom_range(1, 3);
            else hold = $urandom_range(10, 60);
            repeat (hold) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
        end
    end

    function int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [31:0] rand_element();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return 32'h8000_0000;
        if (pick < 10) return 32'h7fff_ffff;
        if (pick < 14) return 32'hffff_ffff;
        if (pick < 17) return 32'h0;
        if (pick < 40) return 32'($signed($urandom_range(0, 64)) - 32);
        return $urandom;
    endfunction

    function logic [4:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return 5'd0;
        if (pick < 18) return 5'd16;
        if (pick < 24) return 5'($urandom_range(17, 31));
        if (pick < 32) return 5'd1;
        return 5'($urandom_range(2, 5));
    endfunction

    // a product may only be formed once every operand it reads holds data
    function bit compute_ready();
        for (int r = 0; r < gen_rows; r++)
            for (int k = 0; k < gen_inner; k++)
                if (!a_written[r*DIM+k]) return 1'b0;
        for (int k = 0; k < gen_inner; k++)
            for (int c = 0; c < gen_cols; c++)
                if (!b_written[k*DIM+c]) return 1'b0;
        return 1'b1;
    endfunction

    // drive one input transaction and hold it until accepted
    task automatic send_item(imm_pkg::op_t op, logic [3:0] row, logic [3:0] col,
                             logic [31:0] value);
        int gap;
        gap = idle_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {value, col, row};
        do @(posedge aclk); while (!s_tready);
        if (op == imm_pkg::OP_WRITE_A && row < gen_rows && col < gen_inner)
            a_written[row*DIM+col] = 1'b1;
        if (op == imm_pkg::OP_WRITE_B && row < gen_inner && col < gen_cols)
            b_written[row*DIM+col] = 1'b1;
        items_sent++;
    endtask

    // apb write: setup cycle then access cycle
    task automatic apb_write(logic [1:0] reg_idx, logic [4:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = imm_pkg::PADDR_W'({reg_idx, 2'b00});
        pwdata  = imm_pkg::APB_W'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_dim(reg_idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // let every result drain, then wait before touching registers
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_dims(logic [4:0] rows, logic [4:0] inner, logic [4:0] cols);
        drain();
        apb_write(imm_pkg::REG_A_ROWS, rows);
        apb_write(imm_pkg::REG_INNER_SIZE, inner);
        apb_write(imm_pkg::REG_B_COLS, cols);
        gen_rows  = (rows > DIM) ? DIM : rows;
        gen_inner = (inner > DIM) ? DIM : inner;
        gen_cols  = (cols > DIM) ? DIM : cols;
    endtask

    // stray transaction at random indices
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: send_item(imm_pkg::OP_WRITE_A, 4'($urandom), 4'($urandom), rand_element());
            1: send_item(imm_pkg::OP_WRITE_B, 4'($urandom), 4'($urandom), rand_element());
            2: begin
                if (compute_ready())
                    send_item(imm_pkg::OP_COMPUTE, 4'($urandom), 4'($urandom), $urandom);
                else
                    send_item(imm_pkg::OP_READ_C, 4'($urandom), 4'($urandom), $urandom);
            end
            default: send_item(imm_pkg::OP_READ_C, 4'($urandom), 4'($urandom), $urandom);
        endcase
    endtask

    // load operands, form the product, read it back
    task automatic run_phase(logic [4:0] rows, logic [4:0] inner, logic [4:0] cols);
        elem_ref_t loads [$];
        elem_ref_t tmp;
        int rounds;
        int j;
        int reads;
        set_dims(rows, inner, cols);
        no_gaps = ($urandom_range(0, 3) == 0);
        rounds  = $urandom_range(1, 3);
        repeat (rounds) begin
            loads.delete();
            for (int r = 0; r < gen_rows; r++)
                for (int k = 0; k < gen_inner; k++)
                    if (!a_written[r*DIM+k] || $urandom_range(0, 99) < 20)
                        loads.push_back('{imm_pkg::OP_WRITE_A, 4'(r), 4'(k)});
            for (int k = 0; k < gen_inner; k++)
                for (int c = 0; c < gen_cols; c++)
                    if (!b_written[k*DIM+c] || $urandom_range(0, 99) < 20)
                        loads.push_back('{imm_pkg::OP_WRITE_B, 4'(k), 4'(c)});
            // shuffle so A and B loads interleave
            for (int i = loads.size() - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = loads[i];
                loads[i] = loads[j];
                loads[j] = tmp;
            end
            foreach (loads[i]) begin
                if ($urandom_range(0, 99) < 12) send_noise();
                send_item(loads[i].op, loads[i].row, loads[i].col, rand_element());
            end
            send_item(imm_pkg::OP_COMPUTE, 4'($urandom), 4'($urandom), $urandom);
            reads = $urandom_range(2, 8);
            repeat (reads) begin
                if (gen_rows != 0 && gen_cols != 0 && $urandom_range(0, 99) < 85)
                    send_item(imm_pkg::OP_READ_C, 4'($urandom_range(0, gen_rows - 1)),
                              4'($urandom_range(0, gen_cols - 1)), $urandom);
                else
                    send_item(imm_pkg::OP_READ_C, 4'($urandom), 4'($urandom), $urandom);
            end
        end
    endtask

    // main sequence
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = imm_pkg::OP_WRITE_A;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_cycles = 0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        gen_rows    = DIM;
        gen_inner   = DIM;
        gen_cols    = DIM;
        foreach (a_written[i]) begin
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // product store reads zero after reset, at both index extremes
        send_item(imm_pkg::OP_READ_C, 4'd0, 4'd0, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd15, 4'd15, 32'hffff_ffff);

        // 2x2 product with extreme operands and out of range accesses
        set_dims(5'd2, 5'd2, 5'd2);
        send_item(imm_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'h7fff_ffff);
        send_item(imm_pkg::OP_WRITE_A, 4'd0, 4'd1, 32'h8000_0000);
        send_item(imm_pkg::OP_WRITE_A, 4'd1, 4'd0, 32'hffff_ffff);
        send_item(imm_pkg::OP_WRITE_A, 4'd1, 4'd1, 32'h0);
        send_item(imm_pkg::OP_WRITE_A, 4'd15, 4'd15, 32'h1234_5678);
        send_item(imm_pkg::OP_WRITE_A, 4'd2, 4'd0, 32'h1);
        send_item(imm_pkg::OP_WRITE_B, 4'd0, 4'd0, 32'h8000_0000);
        send_item(imm_pkg::OP_WRITE_B, 4'd0, 4'd1, 32'hffff_ffff);
        send_item(imm_pkg::OP_WRITE_B, 4'd1, 4'd0, 32'h7fff_ffff);
        send_item(imm_pkg::OP_WRITE_B, 4'd1, 4'd1, 32'h1);
        send_item(imm_pkg::OP_WRITE_B, 4'd0, 4'd2, 32'h5);
        send_item(imm_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd0, 4'd0, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd0, 4'd1, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd1, 4'd0, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd1, 4'd1, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd2, 4'd0, 32'h0);
        send_item(imm_pkg::OP_READ_C, 4'd0, 4'd15, 32'h0);

        // zero dimensions, saturated registers and extreme shapes first
        run_phase(5'd0, 5'd3, 5'd2);
        run_phase(5'd2, 5'd0, 5'd3);
        run_phase(5'd3, 5'd2, 5'd0);
        run_phase(5'd31, 5'd2, 5'd17);
        run_phase(5'd1, 5'd16, 5'd1);
        run_phase(5'd16, 5'd1, 5'd16);
        run_phase(5'd1, 5'd1, 5'd1);
        run_phase(5'd16, 5'd16, 5'd16);

        // random shapes until enough transactions went in
        while (items_sent < ITEM_COUNT)
            run_phase(pick_dim(), pick_dim(), pick_dim());

        drain();
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- integer_matrix_multiply_core.f -----
+incdir+sv
sv/imm_pkg.sv
sv/imm_ram.sv
sv/imm_ctrl.sv
sv/imm_dpath.sv
sv/integer_matrix_multiply_core.sv
verif/integer_matrix_multiply_core_tb.sv
